// File: hdl/tga_rle_pkg.sv
// ============================================================================
// tga_rle_pkg
// Shared types, constants and the microcode table of the TGA pixel decoder.
// ============================================================================
package tga_rle_pkg;

    // Width of the pixel counters and of the pixel_count register.
    localparam int CountW = 24;
    localparam int CfgIdxW = 1;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_DECODE_MODE = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_PIXEL_COUNT = 1'd1;

    // Packet header fields.
    localparam int HdrRepeatBit = 7;
    localparam logic [6:0] HdrCountMask = 7'h7f;

    // Microprogram addresses.
    typedef enum logic [2:0] {
        S_FETCH   = 3'd0,
        S_CHECK   = 3'd1,
        S_HDRTEST = 3'd2,
        S_HDR     = 3'd3,
        S_CHTEST  = 3'd4,
        S_ACCUM   = 3'd5,
        S_ASSEMB  = 3'd6,
        S_EMIT    = 3'd7
    } t_step;

    // Jump conditions; a taken jump goes to the target, otherwise to the next step.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_HALT,
        C_NOT_HDR,
        C_CH_EQ3,
        C_MORE
    } t_cond;

    typedef struct packed {
        logic  in_rd;     // wait for an input word and take it
        logic  chk_done;  // latch done when the count is reached
        logic  hdr_load;  // decode a packet header
        logic  acc;       // store one channel byte
        logic  asm_pix;   // complete the pixel and size the burst
        logic  emit;      // wait for the output register and load a result
        t_cond cond;
        t_step target;
    } t_ctrl;

    typedef struct packed {
        logic in_acc;
        logic out_load;
        logic halt;
        logic not_hdr;
        logic ch_eq3;
        logic more;
    } t_flags;

    function automatic t_ctrl ucode(input t_step step);
        t_ctrl cw;
        cw = '{in_rd: 1'b0, chk_done: 1'b0, hdr_load: 1'b0, acc: 1'b0,
               asm_pix: 1'b0, emit: 1'b0, cond: C_NEVER, target: S_FETCH};
        unique case (step)
            S_FETCH: begin
                cw.in_rd = 1'b1;
            end
            S_CHECK: begin
                cw.chk_done = 1'b1;
                cw.cond     = C_HALT;
                cw.target   = S_FETCH;
            end
            S_HDRTEST: begin
                cw.cond   = C_NOT_HDR;
                cw.target = S_CHTEST;
            end
            S_HDR: begin
                cw.hdr_load = 1'b1;
                cw.cond     = C_ALWAYS;
                cw.target   = S_FETCH;
            end
            S_CHTEST: begin
                cw.cond   = C_CH_EQ3;
                cw.target = S_ASSEMB;
            end
            S_ACCUM: begin
                cw.acc    = 1'b1;
                cw.cond   = C_ALWAYS;
                cw.target = S_FETCH;
            end
            S_ASSEMB: begin
                cw.asm_pix = 1'b1;
            end
            S_EMIT: begin
                // Falls through to S_FETCH by wrapping the step counter.
                cw.emit   = 1'b1;
                cw.cond   = C_MORE;
                cw.target = S_EMIT;
            end
            default: begin
                cw.cond   = C_ALWAYS;
                cw.target = S_FETCH;
            end
        endcase
        return cw;
    endfunction

endpackage

// File: hdl/tga_rle_if.sv
// ============================================================================
// tga_rle_if
// Handshake channels of the TGA pixel decoder: byte input, results, config.
// ============================================================================
interface tga_rle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       image_start;

    modport source (output valid, output data_byte, output image_start, input ready);
    modport sink   (input valid, input data_byte, input image_start, output ready);
endinterface

interface tga_rle_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_first;
    logic [31:0] pixel_second;
    logic [1:0]  pixels_valid;
    logic        last_of_burst;
    logic        image_done;

    modport source (output valid, output pixel_first, output pixel_second,
                    output pixels_valid, output last_of_burst, output image_done,
                    input ready);
    modport sink   (input valid, input pixel_first, input pixel_second,
                    input pixels_valid, input last_of_burst, input image_done,
                    output ready);
endinterface

interface tga_rle_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tga_rle_pkg::CfgIdxW-1:0] index;
    logic [tga_rle_pkg::CountW-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/tga_rle_pixel_decoder.sv
// ============================================================================
// tga_rle_pixel_decoder
// Decodes raw or run-length encoded 32-bit TGA pixel data into pixel pairs.
// ============================================================================
//
//  Channel  | Direction | Word
//  ---------+-----------+---------------------------------------------------
//  i_byte   | in        | data_byte, image_start
//  o_pix    | out       | pixel_first, pixel_second, pixels_valid,
//           |           | last_of_burst, image_done
//  i_cfg    | in        | index (0 decode_mode, 1 pixel_count), data
//
// A microcode sequencer handles one input word at a time: fetch, check, then
// header load, channel store, or pixel assembly and one emit step per result
// (a run of n pixels gives ceil(n/2) results).
// Reset is synchronous and active low; it sets RLE mode and a pixel count of 1.
// A full output register that is not taken stalls the sequencer in its emit
// step, and no input word is taken until the burst has drained.
// The configuration channel is ready whenever reset is released.
module tga_rle_pixel_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tga_rle_in_if.sink    i_byte,
    tga_rle_out_if.source o_pix,
    tga_rle_cfg_if.sink   i_cfg
);

    tga_rle_pkg::t_ctrl  ctrl;
    tga_rle_pkg::t_flags flags;

    tga_rle_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    tga_rle_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .o_flags (flags),
        .i_byte  (i_byte),
        .o_pix   (o_pix),
        .i_cfg   (i_cfg)
    );

endmodule

// File: hdl/tga_rle_seq.sv
// ============================================================================
// tga_rle_seq
// Step counter and microcode ROM: issues one control word per cycle.
// ============================================================================
module tga_rle_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tga_rle_pkg::t_flags i_flags,
    output tga_rle_pkg::t_ctrl  o_ctrl
);

    tga_rle_pkg::t_step r_step;
    tga_rle_pkg::t_step n_step;
    tga_rle_pkg::t_ctrl cw;
    logic               hold;
    logic               taken;

    always_comb begin
        cw = tga_rle_pkg::ucode(r_step);
    end

    always_comb begin
        unique case (cw.cond)
            tga_rle_pkg::C_NEVER:   taken = 1'b0;
            tga_rle_pkg::C_ALWAYS:  taken = 1'b1;
            tga_rle_pkg::C_HALT:    taken = i_flags.halt;
            tga_rle_pkg::C_NOT_HDR: taken = i_flags.not_hdr;
            tga_rle_pkg::C_CH_EQ3:  taken = i_flags.ch_eq3;
            tga_rle_pkg::C_MORE:    taken = i_flags.more;
            default:                taken = 1'b0;
        endcase
    end

    // A step that waits on a handshake holds until it completes.
    assign hold = (cw.in_rd && !i_flags.in_acc) || (cw.emit && !i_flags.out_load);

    always_comb begin
        if (hold) begin
            n_step = r_step;
        end else if (taken) begin
            n_step = cw.target;
        end else begin
            n_step = tga_rle_pkg::t_step'(r_step + 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= tga_rle_pkg::S_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = cw;

endmodule

// File: hdl/tga_rle_dpath.sv
// ============================================================================
// tga_rle_dpath
// Parser state, pixel assembly, counters and the output register.
// ============================================================================
module tga_rle_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tga_rle_pkg::t_ctrl  i_ctrl,
    output tga_rle_pkg::t_flags o_flags,
    tga_rle_in_if.sink          i_byte,
    tga_rle_out_if.source       o_pix,
    tga_rle_cfg_if.sink         i_cfg
);

    localparam int CW = tga_rle_pkg::CountW;

    // Configuration.
    logic          r_mode;
    logic [CW-1:0] r_count;

    // Image state.
    logic          r_phase;    // 1 while packet pixels are expected
    logic          r_repeat;
    logic [7:0]    r_left;
    logic [1:0]    r_ch;
    logic [23:0]   r_partial;
    logic [CW-1:0] r_emitted;
    logic          r_done;

    // Working registers.
    logic [7:0]    r_byte;
    logic [31:0]   r_pixel;
    logic [7:0]    r_n;

    // Output register.
    logic          r_out_valid;
    logic [31:0]   r_out_first;
    logic [31:0]   r_out_second;
    logic [1:0]    r_out_nvalid;
    logic          r_out_last;
    logic          r_out_done;

    logic          in_acc;
    logic          out_load;
    logic          ge;
    logic [1:0]    take;
    logic [7:0]    n_rem;
    logic [CW-1:0] sum;
    logic          sum_ge;
    logic [CW-1:0] remaining;
    logic [7:0]    base;
    logic [7:0]    burst;
    logic [7:0]    left_dec;

    assign in_acc   = i_byte.valid && i_byte.ready;
    assign out_load = i_ctrl.emit && (!r_out_valid || o_pix.ready);
    assign ge       = r_emitted >= r_count;

    assign take   = (r_n >= 8'd2) ? 2'd2 : 2'd1;
    assign n_rem  = r_n - {6'd0, take};
    assign sum    = r_emitted + CW'(take);
    assign sum_ge = sum >= r_count;

    // Burst size: a repeat packet gives its run, anything else one pixel; either is clipped to the pixels still owed.
    assign remaining = r_count - r_emitted;
    always_comb begin
        if (r_mode && r_repeat) begin
            base = (r_left == 8'd0) ? 8'd1 : r_left;
        end else begin
            base = 8'd1;
        end
        if (remaining < CW'(base)) begin
            burst = remaining[7:0];
        end else begin
            burst = base;
        end
    end
    assign left_dec = (r_left != 8'd0) ? (r_left - 8'd1) : 8'd0;

    assign o_flags = '{in_acc: in_acc, out_load: out_load, halt: r_done || ge,
                       not_hdr: !(r_mode && !r_phase), ch_eq3: (r_ch == 2'd3),
                       more: (n_rem != 8'd0)};

    // Neither input channel takes a word while reset is held.
    assign i_byte.ready = i_ctrl.in_rd && i_rst_n;
    assign i_cfg.ready  = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b1;
            r_count <= CW'(1);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                tga_rle_pkg::CFG_DECODE_MODE: r_mode  <= i_cfg.data[0];
                tga_rle_pkg::CFG_PIXEL_COUNT: r_count <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 1'b0;
            r_repeat  <= 1'b0;
            r_left    <= 8'd0;
            r_ch      <= 2'd0;
            r_partial <= 24'd0;
            r_emitted <= '0;
            r_done    <= 1'b0;
        end else begin
            if (i_ctrl.in_rd && in_acc && i_byte.image_start) begin
                r_phase   <= 1'b0;
                r_repeat  <= 1'b0;
                r_left    <= 8'd0;
                r_ch      <= 2'd0;
                r_partial <= 24'd0;
                r_emitted <= '0;
                r_done    <= 1'b0;
            end
            if (i_ctrl.chk_done && ge) begin
                r_done <= 1'b1;
            end
            if (i_ctrl.hdr_load) begin
                r_repeat  <= r_byte[tga_rle_pkg::HdrRepeatBit];
                r_left    <= {1'b0, r_byte[6:0] & tga_rle_pkg::HdrCountMask} + 8'd1;
                r_phase   <= 1'b1;
                r_ch      <= 2'd0;
                r_partial <= 24'd0;
            end
            if (i_ctrl.acc) begin
                r_partial <= r_partial | (24'(r_byte) << {r_ch, 3'b000});
                r_ch      <= r_ch + 2'd1;
            end
            if (i_ctrl.asm_pix) begin
                r_ch      <= 2'd0;
                r_partial <= 24'd0;
                if (r_mode) begin
                    if (r_repeat) begin
                        r_left  <= 8'd0;
                        r_phase <= 1'b0;
                    end else begin
                        r_left <= left_dec;
                        if (left_dec == 8'd0) begin
                            r_phase <= 1'b0;
                        end
                    end
                end
            end
            if (out_load) begin
                r_emitted <= sum;
                if (sum_ge) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.in_rd && in_acc) begin
            r_byte <= i_byte.data_byte;
        end
        if (i_ctrl.asm_pix) begin
            r_pixel <= {r_byte, r_partial};
            r_n     <= burst;
        end
        if (out_load) begin
            r_n <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_first  <= r_pixel;
            r_out_second <= (take == 2'd2) ? r_pixel : 32'd0;
            r_out_nvalid <= take;
            r_out_last   <= (n_rem == 8'd0);
            r_out_done   <= r_done || sum_ge;
        end
    end

    assign o_pix.valid         = r_out_valid;
    assign o_pix.pixel_first   = r_out_first;
    assign o_pix.pixel_second  = r_out_second;
    assign o_pix.pixels_valid  = r_out_nvalid;
    assign o_pix.last_of_burst = r_out_last;
    assign o_pix.image_done    = r_out_done;

endmodule

// File: tb/tga_rle_pixel_decoder_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tga_rle_pixel_decoder_tb
// Self-checking bench for the TGA pixel decoder. A table of directed words
// comes first, followed by random raw and run-length encoded images under
// several idle and stall patterns and one long output hold-off. Each word
// that is accepted goes through a behavioral decoder, and every pixel word
// that comes out is compared with the oldest prediction.
// ============================================================================
module tga_rle_pixel_decoder_tb;

    localparam int HalfPeriod = 10;
    localparam int ResetCycles = 12;
    localparam int SettleCycles = 12;
    localparam int DrainCycles = 32;
    localparam int WatchdogLimit = 5000;
    localparam int HoldCycles = 400;
    localparam int PhaseBytes = 100;
    localparam int DirRows = 31;
    localparam logic [tga_rle_pkg::CountW-1:0] CountMax = '1;
    localparam int GapPct[4] = '{0, 87, 0, 10};
    localparam int StallPct[4] = '{0, 0, 87, 10};

    typedef struct packed {
        logic [31:0] first;
        logic [31:0] second;
        logic [1:0]  nvalid;
        logic        last;
        logic        done;
    } t_pix_word;

    typedef enum logic {
        ROW_BYTE,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind                       kind;
        logic [7:0]                      data;
        logic                            start;
        logic [tga_rle_pkg::CfgIdxW-1:0] reg_index;
        logic [tga_rle_pkg::CountW-1:0]  reg_value;
        logic                            typed;
        t_pix_word                       word;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tga_rle_in_if  byte_if ();
    tga_rle_out_if pix_if ();
    tga_rle_cfg_if cfg_if ();

    tga_rle_pixel_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_if),
        .o_pix   (pix_if),
        .i_cfg   (cfg_if)
    );

    // Decoder state as the testbench tracks it.
    logic                           rle_mode;
    logic [tga_rle_pkg::CountW-1:0] image_pixels;
    logic                           in_packet;
    logic                           run_repeat;
    logic [7:0]                     pkt_left;
    logic [1:0]                     chan;
    logic [23:0]                    part_pixel;
    logic [tga_rle_pkg::CountW-1:0] emitted;
    logic                           img_done;

    t_pix_word   pixel_words_due[$];
    t_stim_row   dir_rows[DirRows];
    int unsigned err_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned phase_end = 0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned quiet_cycles = 0;
    logic        hold_req = 1'b0;

    always begin
        #HalfPeriod i_clk = 1'b1;
        #HalfPeriod i_clk = 1'b0;
    end

    function automatic void clear_image();
        in_packet = 1'b0;
        run_repeat = 1'b0;
        pkt_left = '0;
        chan = '0;
        part_pixel = '0;
        emitted = '0;
        img_done = 1'b0;
    endfunction

    function automatic void push_pixels(input logic [31:0] pix, input int unsigned take,
                                        input logic last);
        t_pix_word w;
        emitted = emitted + tga_rle_pkg::CountW'(take);
        if (emitted >= image_pixels) begin
            img_done = 1'b1;
        end
        w.first = pix;
        w.second = (take == 2) ? pix : 32'd0;
        w.nvalid = 2'(take);
        w.last = last;
        w.done = img_done;
        pixel_words_due = {pixel_words_due, w};
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic s);
        logic [31:0]                    pix;
        logic [tga_rle_pkg::CountW-1:0] left_to_count;
        int unsigned                    n;
        int unsigned                    take;
        if (s) begin
            clear_image();
        end
        if (img_done) begin
            return;
        end
        if (emitted >= image_pixels) begin
            img_done = 1'b1;
            return;
        end
        if (rle_mode && !in_packet) begin
            run_repeat = b[7];
            pkt_left = {1'b0, b[6:0]} + 8'd1;
            in_packet = 1'b1;
            chan = '0;
            part_pixel = '0;
            return;
        end
        if (chan != 2'd3) begin
            part_pixel[8*chan +: 8] = b;
            chan = chan + 2'd1;
            return;
        end
        pix = {b, part_pixel};
        chan = '0;
        part_pixel = '0;
        if (!rle_mode) begin
            push_pixels(pix, 1, 1'b1);
            return;
        end
        if (run_repeat) begin
            n = (pkt_left == 0) ? 1 : pkt_left;
            left_to_count = image_pixels - emitted;
            if (n > left_to_count) begin
                n = 32'(left_to_count);
            end
            while (n > 0) begin
                take = (n >= 2) ? 2 : 1;
                n -= take;
                push_pixels(pix, take, n == 0);
            end
            pkt_left = '0;
            in_packet = 1'b0;
            return;
        end
        push_pixels(pix, 1, 1'b1);
        if (pkt_left != 0) begin
            pkt_left = pkt_left - 8'd1;
        end
        if (pkt_left == 0) begin
            in_packet = 1'b0;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance with
    // valid still high, so the next word can follow without a gap.
    task automatic send_byte(input logic [7:0] b, input logic s, input logic typed,
                             input t_pix_word word);
        int unsigned due_before;
        cfg_if.valid <= 1'b0;
        while ($urandom_range(99) < gap_pct) begin
            byte_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_if.valid <= 1'b1;
        byte_if.data_byte <= b;
        byte_if.image_start <= s;
        @(posedge i_clk);
        while (!byte_if.ready) begin
            @(posedge i_clk);
        end
        due_before = pixel_words_due.size();
        decode_byte(b, s);
        bytes_sent++;
        if (typed) begin
            while (pixel_words_due.size() > due_before) begin
                void'(pixel_words_due.pop_back());
            end
            pixel_words_due = {pixel_words_due, word};
        end
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [tga_rle_pkg::CfgIdxW-1:0] idx,
                             input logic [tga_rle_pkg::CountW-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) begin
            @(posedge i_clk);
        end
        if (idx == tga_rle_pkg::CFG_DECODE_MODE) begin
            rle_mode = value[0];
        end else begin
            image_pixels = value;
        end
        @(negedge i_clk);
    endtask

    // A byte that yields nothing may still be in the sequencer when the last
    // pixel word leaves, so let it settle before touching a register.
    task automatic settle_output();
        byte_if.valid <= 1'b0;
        cfg_if.valid <= 1'b0;
        while (pixel_words_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    // Streams one image; stops early at its packet limit or the phase byte budget.
    task automatic stream_image();
        logic [7:0]  hdr;
        logic        lead;
        logic        flipped;
        int unsigned npix;
        int unsigned packets;
        settle_output();
        if ($urandom_range(4) != 0) begin
            cfg_write(tga_rle_pkg::CFG_DECODE_MODE,
                      tga_rle_pkg::CountW'($urandom_range(3) != 0));
            case ($urandom_range(9))
                0: begin
                    cfg_write(tga_rle_pkg::CFG_PIXEL_COUNT, tga_rle_pkg::CountW'(1));
                end
                1: begin
                    cfg_write(tga_rle_pkg::CFG_PIXEL_COUNT, CountMax);
                end
                2, 3: begin
                    cfg_write(tga_rle_pkg::CFG_PIXEL_COUNT,
                              tga_rle_pkg::CountW'($urandom_range(600, 150)));
                end
                default: begin
                    cfg_write(tga_rle_pkg::CFG_PIXEL_COUNT,
                              tga_rle_pkg::CountW'($urandom_range(48, 2)));
                end
            endcase
        end
        lead = 1'b1;
        packets = $urandom_range(24, 4);
        do begin
            case ($urandom_range(29))
                0: begin
                    // Stray word, sometimes restarting the image mid-packet.
                    send_byte(8'($urandom), $urandom_range(3) == 0, 1'b0, '0);
                    lead = 1'b0;
                end
                1: begin
                    settle_output();
                    if ($urandom_range(1) == 1) begin
                        flipped = ~rle_mode;
                        cfg_write(tga_rle_pkg::CFG_DECODE_MODE,
                                  tga_rle_pkg::CountW'(flipped));
                    end else begin
                        cfg_write(tga_rle_pkg::CFG_PIXEL_COUNT,
                                  tga_rle_pkg::CountW'($urandom_range(64, 1)));
                    end
                end
                default: begin
                    npix = 1;
                    if (rle_mode) begin
                        hdr[7] = 1'($urandom_range(1));
                        if (hdr[7]) begin
                            hdr[6:0] = ($urandom_range(2) == 0) ? 7'($urandom_range(127))
                                                                : 7'($urandom_range(5));
                        end else begin
                            hdr[6:0] = ($urandom_range(15) == 0) ? 7'($urandom_range(127))
                                                                 : 7'($urandom_range(3));
                        end
                        send_byte(hdr, lead, 1'b0, '0);
                        lead = 1'b0;
                        npix = hdr[7] ? 1 : hdr[6:0] + 1;
                    end
                    repeat (4 * npix) begin
                        if (bytes_sent >= phase_end) begin
                            break;
                        end
                        send_byte(8'($urandom), lead, 1'b0, '0);
                        lead = 1'b0;
                    end
                end
            endcase
            packets--;
        end while (!img_done && packets != 0 && bytes_sent < phase_end);
    endtask

    function automatic t_stim_row byte_row(input logic [7:0] d, input logic s);
        t_stim_row r;
        r = '0;
        r.kind = ROW_BYTE;
        r.data = d;
        r.start = s;
        return r;
    endfunction

    function automatic t_stim_row pixel_row(input logic [7:0] d, input logic [31:0] first,
                                            input logic [31:0] second,
                                            input logic [1:0] nvalid, input logic done);
        t_stim_row r;
        r = byte_row(d, 1'b0);
        r.typed = 1'b1;
        r.word = '{first: first, second: second, nvalid: nvalid, last: 1'b1, done: done};
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic [tga_rle_pkg::CfgIdxW-1:0] idx,
                                          input logic [tga_rle_pkg::CountW-1:0] value);
        t_stim_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.reg_index = idx;
        r.reg_value = value;
        return r;
    endfunction

    always begin
        @(negedge i_clk);
        if (hold_req) begin
            hold_req = 1'b0;
            pix_if.ready <= 1'b0;
            repeat (HoldCycles) @(negedge i_clk);
        end
        pix_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_pix_word want;
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            if (pixel_words_due.size() == 0) begin
                $error("unexpected pixel word: pixel_first %h, pixels_valid %0d",
                       pix_if.pixel_first, pix_if.pixels_valid);
                err_count++;
            end else begin
                want = pixel_words_due.pop_front();
                if (pix_if.pixel_first !== want.first) begin
                    $error("pixel_first: expected %h, got %h", want.first, pix_if.pixel_first);
                    err_count++;
                end
                if (pix_if.pixel_second !== want.second) begin
                    $error("pixel_second: expected %h, got %h", want.second,
                           pix_if.pixel_second);
                    err_count++;
                end
                if (pix_if.pixels_valid !== want.nvalid) begin
                    $error("pixels_valid: expected %0d, got %0d", want.nvalid,
                           pix_if.pixels_valid);
                    err_count++;
                end
                if (pix_if.last_of_burst !== want.last) begin
                    $error("last_of_burst: expected %b, got %b", want.last,
                           pix_if.last_of_burst);
                    err_count++;
                end
                if (pix_if.image_done !== want.done) begin
                    $error("image_done: expected %b, got %b", want.done, pix_if.image_done);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((byte_if.valid && byte_if.ready) || (pix_if.valid && pix_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WatchdogLimit) begin
            $display("tga_rle_pixel_decoder regression: fail");
            $finish;
        end
    end

    initial begin
        t_stim_row row;
        i_rst_n = 1'b0;
        byte_if.valid = 1'b0;
        byte_if.data_byte = '0;
        byte_if.image_start = 1'b0;
        pix_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = tga_rle_pkg::CFG_DECODE_MODE;
        cfg_if.data = '0;
        rle_mode = 1'b1;
        image_pixels = tga_rle_pkg::CountW'(1);
        clear_image();

        dir_rows = '{
            cfg_row(tga_rle_pkg::CFG_PIXEL_COUNT, tga_rle_pkg::CountW'(6)),
            // Repeat run of two, every channel at an extreme.
            byte_row(8'h81, 1'b1),
            byte_row(8'h00, 1'b0),
            byte_row(8'hFF, 1'b0),
            byte_row(8'h00, 1'b0),
            pixel_row(8'hFF, 32'hFF00FF00, 32'hFF00FF00, 2'd2, 1'b0),
            // Literal packet of one pixel: second slot stays zero.
            byte_row(8'h00, 1'b0),
            byte_row(8'h11, 1'b0),
            byte_row(8'h22, 1'b0),
            byte_row(8'h33, 1'b0),
            pixel_row(8'h44, 32'h44332211, 32'd0, 2'd1, 1'b0),
            // A 128-pixel run cut at the pixel count, ending on a single pixel.
            byte_row(8'hFF, 1'b0),
            byte_row(8'h01, 1'b0),
            byte_row(8'h02, 1'b0),
            byte_row(8'h03, 1'b0),
            byte_row(8'h04, 1'b0),
            byte_row(8'h55, 1'b0),
            cfg_row(tga_rle_pkg::CFG_DECODE_MODE, tga_rle_pkg::CountW'(0)),
            cfg_row(tga_rle_pkg::CFG_PIXEL_COUNT, CountMax),
            byte_row(8'hA5, 1'b1),
            byte_row(8'h5A, 1'b0),
            byte_row(8'h00, 1'b0),
            pixel_row(8'h80, 32'h80005AA5, 32'd0, 2'd1, 1'b0),
            // Back to run-length mode without a new image.
            cfg_row(tga_rle_pkg::CFG_DECODE_MODE, tga_rle_pkg::CountW'(1)),
            byte_row(8'h82, 1'b0),
            byte_row(8'h10, 1'b0),
            byte_row(8'h20, 1'b0),
            byte_row(8'h30, 1'b0),
            byte_row(8'h40, 1'b0),
            // Count lowered below what was already produced.
            cfg_row(tga_rle_pkg::CFG_PIXEL_COUNT, tga_rle_pkg::CountW'(2)),
            byte_row(8'h00, 1'b0)
        };

        repeat (ResetCycles) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG) begin
                settle_output();
                cfg_write(row.reg_index, row.reg_value);
            end else begin
                send_byte(row.data, row.start, row.typed, row.word);
            end
        end

        for (int p = 0; p < 4; p++) begin
            phase_end = bytes_sent + PhaseBytes;
            gap_pct = GapPct[p];
            stall_pct = StallPct[p];
            while (bytes_sent < phase_end) begin
                stream_image();
            end
        end

        // Hold the output off while long runs keep arriving, so the input backs up.
        settle_output();
        gap_pct = 0;
        stall_pct = 0;
        cfg_write(tga_rle_pkg::CFG_DECODE_MODE, tga_rle_pkg::CountW'(1));
        cfg_write(tga_rle_pkg::CFG_PIXEL_COUNT, CountMax);
        hold_req = 1'b1;
        for (int k = 0; k < 6; k++) begin
            send_byte(8'hFF, k == 0, 1'b0, '0);
            repeat (4) send_byte(8'($urandom), 1'b0, 1'b0, '0);
        end

        byte_if.valid <= 1'b0;
        while (pixel_words_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tga_rle_pixel_decoder regression: pass");
        end else begin
            $display("tga_rle_pixel_decoder regression: fail");
        end
        $finish;
    end

endmodule
